// ===== src/barometric_sensor_compensation_core_macros.svh =====
// Assertion macros shared by the checker of the compensation core.
`ifndef BAROMETRIC_SENSOR_COMPENSATION_CORE_MACROS_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BSC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define BSC_ASSERT_NXT_ANY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/bsc_pkg.sv =====
// Shared types, constants and calibration decoding for the compensation core.
package bsc_pkg;

    localparam int RAW_W     = 24;
    localparam int TEMP_W    = 16;
    localparam int PRESS_W   = 23;
    localparam int CFG_W     = 64;
    localparam int HIGH_W    = 40;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MID  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH = 2'd2;

    localparam int QUEUE_DEPTH = 4;

    // Multiplier partial products are CW x CW; the adder tree has 2**MUL_TREE_LV leaves.
    localparam int MUL_CW      = 32;
    localparam int MUL_TREE_LV = 4;
    localparam int MUL_LAT     = 3 + MUL_TREE_LV;

    localparam int ACC_W       = 212;
    localparam int PRESS_SHIFT = 175;
    localparam int PRESS_MAX   = 8388607;
    localparam int TEMP_MAX    = 32767;
    localparam int TEMP_MIN    = -32768;

    typedef logic signed [ACC_W-1:0] acc_t;

    typedef struct packed {
        logic [RAW_W-1:0] raw_pressure;
        logic [RAW_W-1:0] raw_temperature;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } qhead_t;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [16:0] t2;
        logic signed [7:0]  t3;
        logic signed [17:0] p1m;
        logic signed [17:0] p2m;
        logic signed [7:0]  p3;
        logic signed [7:0]  p4;
        logic signed [16:0] p5;
        logic signed [16:0] p6;
        logic signed [7:0]  p7;
        logic signed [7:0]  p8;
        logic signed [15:0] p9;
        logic signed [7:0]  p10;
        logic signed [7:0]  p11;
    } coef_t;

    // Unpacks the 21 little-endian calibration bytes into coefficients; t1, t2, p5 and p6 are read as unsigned.
    function automatic coef_t cal_decode(input logic [CFG_W-1:0] lo,
                                         input logic [CFG_W-1:0] mid,
                                         input logic [HIGH_W-1:0] hi);
        logic [2*CFG_W+HIGH_W-1:0] b;
        coef_t c;
        b      = {hi, mid, lo};
        c.t1   = b[15:0];
        c.t2   = $signed({1'b0, b[31:16]});
        c.t3   = $signed(b[39:32]);
        c.p1m  = $signed({{2{b[55]}}, b[55:40]}) - 18'sd16384;
        c.p2m  = $signed({{2{b[71]}}, b[71:56]}) - 18'sd16384;
        c.p3   = $signed(b[79:72]);
        c.p4   = $signed(b[87:80]);
        c.p5   = $signed({1'b0, b[103:88]});
        c.p6   = $signed({1'b0, b[119:104]});
        c.p7   = $signed(b[127:120]);
        c.p8   = $signed(b[135:128]);
        c.p9   = $signed(b[151:136]);
        c.p10  = $signed(b[159:152]);
        c.p11  = $signed(b[167:160]);
        return c;
    endfunction

endpackage

// ===== src/bsc_mul.sv =====
// Pipelined signed multiplier built from CW x CW partial products and a registered adder tree.
module bsc_mul #(
    parameter int AW = 8,
    parameter int BW = 8
) (
    input  logic                      aclk,
    input  logic                      en,
    input  logic signed [AW-1:0]      a,
    input  logic signed [BW-1:0]      b,
    output logic signed [AW+BW-1:0]   p
);

    localparam int CW = bsc_pkg::MUL_CW;
    localparam int NA = (AW + CW - 1) / CW;
    localparam int NB = (BW + CW - 1) / CW;
    localparam int NP = NA * NB;
    localparam int LV = bsc_pkg::MUL_TREE_LV;
    localparam int NL = 2 ** LV;
    localparam int PW = AW + BW;
    localparam int XW = (NA + NB) * CW;

    logic [AW-1:0]      abs_a;
    logic [BW-1:0]      abs_b;
    logic [NA*CW-1:0]   ma_reg;
    logic [NB*CW-1:0]   mb_reg;
    logic [LV+1:0]      sg_reg;
    logic [PW-1:0]      node_reg [0:2*NL-2];
    logic [PW-1:0]      p_reg;

    // Work on magnitudes; the sign is reapplied after the tree.
    assign abs_a = a[AW-1] ? AW'(-a) : AW'(a);
    assign abs_b = b[BW-1] ? BW'(-b) : BW'(b);

    always_ff @(posedge aclk) begin
        if (en) begin
            ma_reg <= (NA*CW)'(abs_a);
            mb_reg <= (NB*CW)'(abs_b);
            sg_reg <= {sg_reg[LV:0], a[AW-1] ^ b[BW-1]};
        end
    end

    for (genvar i = 0; i < NL; i++) begin : g_leaf
        if (i < NP) begin : g_pp
            localparam int IA = i / NB;
            localparam int IB = i % NB;
            logic [2*CW-1:0] pp;
            assign pp = ma_reg[IA*CW +: CW] * mb_reg[IB*CW +: CW];
            always_ff @(posedge aclk) begin
                if (en) begin
                    node_reg[NL-1+i] <= PW'(XW'(pp) << ((IA + IB) * CW));
                end
            end
        end else begin : g_zero
            always_ff @(posedge aclk) begin
                node_reg[NL-1+i] <= '0;
            end
        end
    end

    for (genvar n = 0; n < NL - 1; n++) begin : g_node
        always_ff @(posedge aclk) begin
            if (en) begin
                node_reg[n] <= node_reg[2*n+1] + node_reg[2*n+2];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= sg_reg[LV+1] ? -node_reg[0] : node_reg[0];
        end
    end

    assign p = $signed(p_reg);

endmodule

// ===== src/bsc_delay.sv =====
// Enabled delay line that keeps operands aligned across the pipeline.
module bsc_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);

    logic [W-1:0] tap_reg [0:N-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= d;
            for (int k = 1; k < N; k++) begin
                tap_reg[k] <= tap_reg[k-1];
            end
        end
    end

    assign q = tap_reg[N-1];

endmodule

// ===== src/bsc_queue.sv =====
// Front end: accepts requests and holds them in a short queue for the compute pipeline.
module bsc_queue #(
    parameter int DEPTH = bsc_pkg::QUEUE_DEPTH
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  bsc_pkg::item_t  s_item,
    input  logic            pop,
    output bsc_pkg::qhead_t head
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bsc_pkg::item_t   mem_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push;

    assign s_ready = (cnt_reg != CNT_W'(DEPTH));
    assign push    = s_valid && s_ready;

    // Pointers wrap at the last slot so depths that are not a power of two work.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= s_item;
        end
    end

    assign head.valid = (cnt_reg != '0);
    assign head.item  = mem_reg[rd_ptr_reg];

endmodule

// ===== src/bsc_back.sv =====
// Back end: a pipeline, stalled as a whole, that evaluates temperature and the pressure polynomial.
module bsc_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  bsc_pkg::coef_t        coef,
    input  bsc_pkg::qhead_t       head,
    output logic                  pop,
    input  logic                  m_ready,
    output logic                  m_valid,
    output logic signed [15:0]    m_temperature_q8,
    output logic [22:0]           m_pressure_q6,
    output logic                  m_in_range
);

    localparam int L      = bsc_pkg::MUL_LAT;
    localparam int TTN    = 2 * L + 1;
    localparam int TSUM   = TTN + 3 * L;
    localparam int TA2    = TTN + L + 1;
    localparam int TFIN   = TSUM + 1 + L;
    localparam int NSTG   = TFIN + 3;
    localparam int TN_W   = 61;
    localparam int A1_W   = 193;
    localparam int A2_W   = 156;
    localparam int ACC_W  = bsc_pkg::ACC_W;
    localparam int PSH    = bsc_pkg::PRESS_SHIFT;
    localparam int PR_W   = ACC_W - PSH;
    localparam int X_W    = TN_W + 1;
    localparam int Q_W    = X_W - 40;

    localparam bsc_pkg::acc_t RND = bsc_pkg::acc_t'(1) <<< (PSH - 1);

    logic                  en;
    logic [NSTG-1:0]       vld_reg;
    logic [23:0]           u0_reg, rt0_reg;
    logic signed [24:0]    d, u_s, u_d1, u_d2;
    logic signed [41:0]    dt2, dt2_d;
    logic signed [49:0]    dd, uu, uu_d;
    logic signed [57:0]    ddt3;
    logic signed [74:0]    u3;
    logic signed [82:0]    a3, a3_d;
    logic signed [TN_W-1:0] tn_reg, tn_d1, tn_d2;
    logic signed [121:0]   ts;
    logic signed [182:0]   tc;
    logic signed [77:0]    tp6, tp6_d;
    logic signed [78:0]    tp2, tp2_d;
    logic signed [68:0]    tp10;
    logic signed [129:0]   sp7, sp7_d, sp3, sp3_d;
    logic signed [190:0]   cp8, cp4;
    logic signed [A2_W-1:0] a2_reg;
    logic signed [205:0]   a2u2, a2u2_d;
    logic signed [A1_W-1:0] a1_reg;
    logic signed [217:0]   a1u;
    bsc_pkg::acc_t         a0_reg, a0_d, acc_reg;
    logic signed [X_W-1:0] tx;
    logic signed [Q_W-1:0] tq;
    logic [PR_W-1:0]       pr;
    logic signed [15:0]    temp_next;
    logic [22:0]           press_next;
    logic                  ok_next, t_ok, p_ok;
    logic signed [15:0]    temp_reg;
    logic [22:0]           press_reg;
    logic                  ok_reg;

    // The whole pipeline advances unless a finished result is waiting.
    assign en  = !vld_reg[NSTG-1] || m_ready;
    assign pop = en && head.valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTG-2:0], pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u0_reg  <= head.item.raw_pressure;
            rt0_reg <= head.item.raw_temperature;
        end
    end

    assign d   = $signed({1'b0, rt0_reg}) - $signed({1'b0, coef.t1, 8'd0});
    assign u_s = $signed({1'b0, u0_reg});

    // Temperature numerator tn = d*T2*2^18 + d*d*T3.
    bsc_mul #(.AW(25), .BW(17)) u_m_dt2 (.aclk, .en, .a(d), .b(coef.t2), .p(dt2));
    bsc_mul #(.AW(25), .BW(25)) u_m_dd  (.aclk, .en, .a(d), .b(d), .p(dd));
    bsc_mul #(.AW(50), .BW(8))  u_m_ddt3 (.aclk, .en, .a(dd), .b(coef.t3), .p(ddt3));
    bsc_delay #(.W(42), .N(L)) u_d_dt2 (.aclk, .en, .d(dt2), .q(dt2_d));

    always_ff @(posedge aclk) begin
        if (en) begin
            tn_reg <= (TN_W'(dt2_d) <<< 18) + TN_W'(ddt3);
        end
    end

    // Powers of the raw pressure.
    bsc_mul #(.AW(25), .BW(25)) u_m_uu (.aclk, .en, .a(u_s), .b(u_s), .p(uu));
    bsc_delay #(.W(25), .N(L)) u_d_u1 (.aclk, .en, .d(u_s), .q(u_d1));
    bsc_mul #(.AW(50), .BW(25)) u_m_u3 (.aclk, .en, .a(uu), .b(u_d1), .p(u3));
    bsc_mul #(.AW(75), .BW(8))  u_m_a3 (.aclk, .en, .a(u3), .b(coef.p11), .p(a3));

    // Powers of the temperature numerator.
    bsc_mul #(.AW(TN_W), .BW(TN_W)) u_m_ts (.aclk, .en, .a(tn_reg), .b(tn_reg), .p(ts));
    bsc_delay #(.W(TN_W), .N(L)) u_d_tn1 (.aclk, .en, .d(tn_reg), .q(tn_d1));
    bsc_mul #(.AW(122), .BW(TN_W)) u_m_tc (.aclk, .en, .a(ts), .b(tn_d1), .p(tc));

    // Coefficient products.
    bsc_mul #(.AW(TN_W), .BW(17)) u_m_tp6  (.aclk, .en, .a(tn_reg), .b(coef.p6), .p(tp6));
    bsc_mul #(.AW(TN_W), .BW(18)) u_m_tp2  (.aclk, .en, .a(tn_reg), .b(coef.p2m), .p(tp2));
    bsc_mul #(.AW(TN_W), .BW(8))  u_m_tp10 (.aclk, .en, .a(tn_reg), .b(coef.p10), .p(tp10));
    bsc_mul #(.AW(122), .BW(8))   u_m_sp7  (.aclk, .en, .a(ts), .b(coef.p7), .p(sp7));
    bsc_mul #(.AW(122), .BW(8))   u_m_sp3  (.aclk, .en, .a(ts), .b(coef.p3), .p(sp3));
    bsc_mul #(.AW(183), .BW(8))   u_m_cp8  (.aclk, .en, .a(tc), .b(coef.p8), .p(cp8));
    bsc_mul #(.AW(183), .BW(8))   u_m_cp4  (.aclk, .en, .a(tc), .b(coef.p4), .p(cp4));

    bsc_delay #(.W(78), .N(2*L))  u_d_tp6 (.aclk, .en, .d(tp6), .q(tp6_d));
    bsc_delay #(.W(79), .N(2*L))  u_d_tp2 (.aclk, .en, .d(tp2), .q(tp2_d));
    bsc_delay #(.W(130), .N(L))   u_d_sp7 (.aclk, .en, .d(sp7), .q(sp7_d));
    bsc_delay #(.W(130), .N(L))   u_d_sp3 (.aclk, .en, .d(sp3), .q(sp3_d));

    // Coefficient of u^2, then its product with u^2.
    always_ff @(posedge aclk) begin
        if (en) begin
            a2_reg <= (A2_W'(coef.p9) <<< 133) + (A2_W'(tp10) <<< 85);
        end
    end

    bsc_delay #(.W(50), .N(TA2-L)) u_d_uu (.aclk, .en, .d(uu), .q(uu_d));
    bsc_mul #(.AW(A2_W), .BW(50)) u_m_a2u2 (.aclk, .en, .a(a2_reg), .b(uu_d), .p(a2u2));

    // Constant and linear coefficients of the polynomial in u.
    always_ff @(posedge aclk) begin
        if (en) begin
            a0_reg <= (bsc_pkg::acc_t'(coef.p5) <<< 184) + (bsc_pkg::acc_t'(tp6_d) <<< 127)
                    + (bsc_pkg::acc_t'(sp7_d) <<< 77) + (bsc_pkg::acc_t'(cp8) <<< 22);
            a1_reg <= (A1_W'(coef.p1m) <<< 161) + (A1_W'(tp2_d) <<< 104)
                    + (A1_W'(sp3_d) <<< 53) + A1_W'(cp4);
        end
    end

    bsc_delay #(.W(25), .N(TSUM+1)) u_d_u2 (.aclk, .en, .d(u_s), .q(u_d2));
    bsc_mul #(.AW(A1_W), .BW(25)) u_m_a1u (.aclk, .en, .a(a1_reg), .b(u_d2), .p(a1u));

    bsc_delay #(.W(ACC_W), .N(L))           u_d_a0   (.aclk, .en, .d(a0_reg), .q(a0_d));
    bsc_delay #(.W(206), .N(TFIN-TA2-L))    u_d_a2u2 (.aclk, .en, .d(a2u2), .q(a2u2_d));
    bsc_delay #(.W(83), .N(TFIN-3*L))       u_d_a3   (.aclk, .en, .d(a3), .q(a3_d));
    bsc_delay #(.W(TN_W), .N(TFIN+1-TTN))   u_d_tn2  (.aclk, .en, .d(tn_reg), .q(tn_d2));

    always_ff @(posedge aclk) begin
        if (en) begin
            acc_reg <= a0_d + bsc_pkg::acc_t'(a1u) + bsc_pkg::acc_t'(a2u2_d)
                     + (bsc_pkg::acc_t'(a3_d) <<< 116) + RND;
        end
    end

    // Rounding and saturation.
    always_comb begin
        tx    = X_W'(tn_d2) + (X_W'(1) <<< 39);
        tq    = Q_W'(tx >>> 40);
        t_ok  = 1'b1;
        if (tq > Q_W'(bsc_pkg::TEMP_MAX)) begin
            temp_next = 16'sh7FFF;
            t_ok      = 1'b0;
        end else if (tq < Q_W'(bsc_pkg::TEMP_MIN)) begin
            temp_next = 16'sh8000;
            t_ok      = 1'b0;
        end else begin
            temp_next = 16'(tq);
        end

        pr   = acc_reg[ACC_W-1:PSH];
        p_ok = 1'b1;
        if (acc_reg[ACC_W-1]) begin
            press_next = '0;
            p_ok       = 1'b0;
        end else if (pr > PR_W'(bsc_pkg::PRESS_MAX)) begin
            press_next = 23'(bsc_pkg::PRESS_MAX);
            p_ok       = 1'b0;
        end else begin
            press_next = pr[22:0];
        end
        ok_next = t_ok && p_ok;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            temp_reg  <= temp_next;
            press_reg <= press_next;
            ok_reg    <= ok_next;
        end
    end

    assign m_valid          = vld_reg[NSTG-1];
    assign m_temperature_q8 = temp_reg;
    assign m_pressure_q6    = press_reg;
    assign m_in_range       = ok_reg;

endmodule

// ===== src/barometric_sensor_compensation_core.sv =====
// Throughput: one request per cycle while the output is not stalled; the compute pipeline has no loops.
// The pipeline depth is set by six chained multiplier stages plus alignment and rounding.
// Reset (aresetn, synchronous, active low) empties the queue and pipeline and clears calibration.
// A stalled result freezes the back end; the front queue keeps taking requests until full.
module barometric_sensor_compensation_core #(
    parameter int QUEUE_DEPTH = bsc_pkg::QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Request channel.
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [23:0]           s_raw_pressure,
    input  logic [23:0]           s_raw_temperature,
    // Result channel.
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [15:0]    m_temperature_q8,
    output logic [22:0]           m_pressure_q6,
    output logic                  m_in_range,
    // Calibration write port.
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [63:0]           cfg_data
);

    // The three calibration words; the user must change them only while the core is idle (not enforced).
    logic [63:0]     cal_low_reg;
    logic [63:0]     cal_mid_reg;
    logic [39:0]     cal_high_reg;

    bsc_pkg::coef_t  coef;
    bsc_pkg::item_t  s_item;
    bsc_pkg::qhead_t head;
    logic            pop;

    // Register writes; an index past the last register is simply dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_low_reg  <= '0;
            cal_mid_reg  <= '0;
            cal_high_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bsc_pkg::REG_LOW:  cal_low_reg  <= cfg_data;
                bsc_pkg::REG_MID:  cal_mid_reg  <= cfg_data;
                bsc_pkg::REG_HIGH: cal_high_reg <= cfg_data[39:0];
                default: ;
            endcase
        end
    end

    // Coefficients are a pure function of the stored bytes.
    assign coef = bsc_pkg::cal_decode(cal_low_reg, cal_mid_reg, cal_high_reg);

    assign s_item.raw_pressure    = s_raw_pressure;
    assign s_item.raw_temperature = s_raw_temperature;

    // Front end: a short queue decouples acceptance from the pipeline stall.
    bsc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .pop     (pop),
        .head    (head)
    );

    // Back end: the compensation arithmetic, advancing whenever the result slot frees up.
    bsc_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .coef             (coef),
        .head             (head),
        .pop              (pop),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_temperature_q8 (m_temperature_q8),
        .m_pressure_q6    (m_pressure_q6),
        .m_in_range       (m_in_range)
    );

endmodule

// ===== src/bsc_checker.sv =====
// Port-level assertions for the compensation core, bound to its top level.
`include "barometric_sensor_compensation_core_macros.svh"

module bsc_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic signed [15:0]  m_temperature_q8,
    input logic [22:0]         m_pressure_q6,
    input logic                m_in_range
);

    `BSC_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid, "result dropped while stalled")
    `BSC_ASSERT_NXT(a_out_stable, m_valid && !m_ready, $stable(m_temperature_q8) && $stable(m_pressure_q6) && $stable(m_in_range), "result changed while stalled")
    `BSC_ASSERT_IMP(a_range_flag, m_valid && !m_in_range, m_temperature_q8 == 16'sh7FFF || m_temperature_q8 == 16'sh8000 || m_pressure_q6 == 23'd0 || m_pressure_q6 == 23'h7FFFFF, "out-of-range flag without a saturated value")
    `BSC_ASSERT_NXT_ANY(a_reset_empty, !aresetn, !m_valid && s_ready, "core not empty after reset")

endmodule

bind barometric_sensor_compensation_core bsc_checker u_bsc_checker (.*);
